/* rtl/s256_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// s256_pkg
// Shared types, constants and round functions of the SHA-256 byte digest.
// ============================================================================
package s256_pkg;

    localparam int CNT_BITS_DEF = 61;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;

    typedef logic [15:0][31:0] t_block;
    typedef logic [7:0][31:0] t_chain;

    typedef struct packed {
        logic start;
        logic init;
    } t_eng_ctrl;

    typedef struct packed {
        logic done;
    } t_eng_stat;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

/* rtl/s256_round.sv */
`timescale 1ns / 1ps
// ============================================================================
// s256_round
// Compression engine: one SHA-256 round per cycle over a 16-word schedule
// window, then a chaining-value update. Holds the chaining value.
// ============================================================================
module s256_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  s256_pkg::t_eng_ctrl i_ctrl,
    input  s256_pkg::t_block   i_block,
    output s256_pkg::t_eng_stat o_stat,
    output s256_pkg::t_chain   o_chain
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_RUN,
        E_FIN
    } t_eng_state;

    t_eng_state        r_state;
    logic [5:0]        r_round;
    s256_pkg::t_block  r_w;
    s256_pkg::t_chain  r_v;
    s256_pkg::t_chain  r_chain;

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;
    logic [31:0] w_sched;

    always_comb begin
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + s256_pkg::f_bsig1(r_v[4]) + w_ch
                  + s256_pkg::ROUND_K[r_round] + r_w[0];
        w_t2    = s256_pkg::f_bsig0(r_v[0]) + w_maj;
        w_sched = r_w[0] + s256_pkg::f_ssig0(r_w[1]) + r_w[9]
                  + s256_pkg::f_ssig1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= s256_pkg::INIT_HASH[i];
            end
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_ctrl.init) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= s256_pkg::INIT_HASH[i];
                        end
                    end
                    if (i_ctrl.start) begin
                        r_w     <= i_block;
                        r_v     <= r_chain;
                        r_round <= '0;
                        r_state <= E_RUN;
                    end
                end
                E_RUN: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_sched;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= E_FIN;
                    end
                end
                E_FIN: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done = (r_state == E_FIN);
    assign o_chain     = r_chain;

endmodule

/* rtl/sha256_message_digest.sv */
`timescale 1ns / 1ps
// ============================================================================
// sha256_message_digest
// SHA-256 over a byte stream; one 256-bit digest per message.
// ============================================================================
// Throughput: one byte per cycle while a block fills; the byte that completes a
//   block holds input off while it is compressed (load, 64 rounds in the round unit,
//   chaining update). After the final byte, padding fills out the block, one or
//   two blocks are compressed, then the digest is registered once the output is free.
// Reset: synchronous, active low; loads the initial hash, clears the counters
//   and the output register valid.
module sha256_message_digest #(
    parameter int LENGTH_COUNTER_BITS = s256_pkg::CNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] message_byte
    input  logic         i_s_axis_tlast,   // is_last
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [255:0] o_m_axis_tdata    // digest_word_0 .. digest_word_7, 32 bits each
);

    localparam int CW = LENGTH_COUNTER_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_START,
        S_COMP,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [5:0]              r_fill, n_fill;
    logic [CW-1:0]           r_byte_cnt, n_byte_cnt;
    logic [63:0]             r_len, n_len;
    logic                    r_pad, n_pad;
    logic                    r_mark, n_mark;
    logic                    r_len_here, n_len_here;
    logic                    r_final, n_final;
    logic                    r_out_valid, n_out_valid;
    logic [255:0]            r_out, n_out;
    s256_pkg::t_block        r_buf;

    logic                    w_wr;
    logic [7:0]              w_wr_byte;
    logic [CW-1:0]           w_cnt_inc;
    s256_pkg::t_eng_ctrl     w_ctrl;
    s256_pkg::t_eng_stat     w_stat;
    s256_pkg::t_chain        w_chain;

    assign w_cnt_inc = r_byte_cnt + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_byte_cnt  = r_byte_cnt;
        n_len       = r_len;
        n_pad       = r_pad;
        n_mark      = r_mark;
        n_len_here  = r_len_here;
        n_final     = r_final;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;
        w_wr        = 1'b0;
        w_wr_byte   = i_s_axis_tdata;
        w_ctrl      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    w_wr       = 1'b1;
                    n_fill     = r_fill + 6'd1;
                    n_byte_cnt = w_cnt_inc;
                    n_final    = 1'b0;
                    if (i_s_axis_tlast) begin
                        n_pad      = 1'b1;
                        n_mark     = 1'b0;
                        n_len_here = 1'b0;
                        n_len      = 64'({w_cnt_inc, 3'b000});
                    end
                    if (r_fill == s256_pkg::FILL_LAST) begin
                        n_state = S_START;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_wr   = 1'b1;
                n_fill = r_fill + 6'd1;
                if (!r_mark) begin
                    w_wr_byte  = s256_pkg::PAD_MARK;
                    n_mark     = 1'b1;
                    n_len_here = (r_fill < s256_pkg::LEN_POS);
                end else if (r_len_here && r_fill >= s256_pkg::LEN_POS) begin
                    w_wr_byte = r_len[63:56];
                    n_len     = {r_len[55:0], 8'd0};
                end else begin
                    w_wr_byte = 8'd0;
                end
                if (r_fill == s256_pkg::FILL_LAST) begin
                    n_final    = r_len_here;
                    n_len_here = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                w_ctrl.start = 1'b1;
                n_state      = S_COMP;
            end
            S_COMP: begin
                if (w_stat.done) begin
                    if (r_final) begin
                        n_state = S_DONE;
                    end else if (r_pad) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = w_chain;
                    n_out_valid = 1'b1;
                    w_ctrl.init = 1'b1;
                    n_pad       = 1'b0;
                    n_final     = 1'b0;
                    n_byte_cnt  = '0;
                    n_fill      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_byte_cnt  <= '0;
            r_pad       <= 1'b0;
            r_mark      <= 1'b0;
            r_len_here  <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_byte_cnt  <= n_byte_cnt;
            r_pad       <= n_pad;
            r_mark      <= n_mark;
            r_len_here  <= n_len_here;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_out <= n_out;
        if (w_wr) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= w_wr_byte;
        end
    end

    s256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_block (r_buf),
        .o_stat  (w_stat),
        .o_chain (w_chain)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule

/* rtl/s256_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// s256_checker
// Port-level checks of the SHA-256 byte digest, bound to the top level.
// ============================================================================
module s256_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic         i_s_axis_tlast,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [255:0] o_m_axis_tdata
);

    logic w_last_xfer;
    assign w_last_xfer = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata))
        else $error("digest dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("digest valid after reset");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_xfer |=> !o_s_axis_tready)
        else $error("input ready right after the final byte");

    a_digest_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("digest appeared without a padding pass");

endmodule

bind sha256_message_digest s256_checker u_s256_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Streams messages one byte per transfer into sha256_message_digest and
// compares every digest word with a behavioral SHA-256 held in the bench.
// Covers short messages, padding at block boundaries, a long output hold-off
// and random messages under random idling on both sides.
// ============================================================================
module testbench;

    localparam int          LEN_BITS     = 16;
    localparam int unsigned RANDOM_ITEMS = 660;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 250;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} t_fill;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;    // [7:0] message_byte
    logic         i_s_axis_tlast = 1'b0;  // is_last
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [255:0] o_m_axis_tdata;         // digest_word_0 .. digest_word_7, 32 bits each

    logic [31:0]         hash_state [8];
    logic [7:0]          msg_block [64];
    int unsigned         block_fill;
    logic [LEN_BITS-1:0] msg_len_bytes;
    s256_pkg::t_chain    digest_q [$];

    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_ack = 0;
    logic        rx_idle_en = 1'b1;
    logic        tx_idle_en = 1'b1;

    sha256_message_digest #(
        .LENGTH_COUNTER_BITS(LEN_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic void reset_hash();
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = s256_pkg::INIT_HASH[i];
        end
        block_fill = 0;
        msg_len_bytes = '0;
    endfunction

    // Buffer one byte; compress when the block is full.
    function automatic void absorb_byte(input logic [7:0] data);
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1;
        logic [31:0] t2;
        msg_block[block_fill] = data;
        block_fill++;
        if (block_fill == 64) begin
            for (int i = 0; i < 16; i++) begin
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            end
            for (int i = 16; i < 64; i++) begin
                w[i] = w[i-16] + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
            end
            for (int i = 0; i < 8; i++) begin
                s[i] = hash_state[i];
            end
            for (int i = 0; i < 64; i++) begin
                t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
                   + ((s[4] & s[5]) ^ (~s[4] & s[6])) + s256_pkg::ROUND_K[i] + w[i];
                t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
                   + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
                s[7] = s[6];
                s[6] = s[5];
                s[5] = s[4];
                s[4] = s[3] + t1;
                s[3] = s[2];
                s[2] = s[1];
                s[1] = s[0];
                s[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) begin
                hash_state[i] = hash_state[i] + s[i];
            end
            block_fill = 0;
        end
    endfunction

    // Advance the running hash by one message byte; pad and queue the digest on the last.
    function automatic void hash_byte(input logic [7:0] data, input logic last);
        logic [63:0]      bit_len;
        s256_pkg::t_chain digest;
        msg_len_bytes = msg_len_bytes + LEN_BITS'(1);
        absorb_byte(data);
        if (last) begin
            bit_len = 64'(msg_len_bytes) << 3;
            absorb_byte(s256_pkg::PAD_MARK);
            while (block_fill != int'(s256_pkg::LEN_POS)) begin
                absorb_byte(8'h00);
            end
            for (int i = 7; i >= 0; i--) begin
                absorb_byte(bit_len[8*i +: 8]);
            end
            for (int i = 0; i < 8; i++) begin
                digest[i] = hash_state[i];
            end
            digest_q = {digest_q, digest};
            reset_hash();
        end
    endfunction

    task automatic set_idling(input logic on);
        tx_idle_en = on;
        rx_idle_en <= on;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        hash_byte(data, last);
    endtask

    task automatic send_message(input int unsigned len, input t_fill kind);
        logic [7:0] data;
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                FILL_ZERO: data = 8'h00;
                FILL_ONES: data = 8'hff;
                FILL_RAMP: data = 8'(i);
                default:   data = 8'($urandom);
            endcase
            send_byte(data, i == len - 1);
        end
    endtask

    task automatic test_short_messages();
        set_idling(1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        send_message(2, FILL_ONES);
    endtask

    // Lengths where the length field just fits, spills into a second block,
    // or the final byte closes a block.
    task automatic test_padding_boundaries();
        int unsigned lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        foreach (lens[i]) begin
            send_message(lens[i], t_fill'(i % 4));
        end
    endtask

    // Hold the output off for a long stretch while short messages keep coming.
    task automatic test_output_backpressure();
        set_idling(1'b0);
        rx_hold_req <= rx_hold_req + 1;
        for (int i = 0; i < 12; i++) begin
            send_message($urandom_range(1, 3), FILL_RANDOM);
        end
        set_idling(1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idling($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                len = $urandom_range(52, 66);
            end else if (r < 70) begin
                len = $urandom_range(1, 64);
            end else if (r < 90) begin
                len = $urandom_range(65, 130);
            end else begin
                len = $urandom_range(131, 300);
            end
            if (len > RANDOM_ITEMS - sent) begin
                len = RANDOM_ITEMS - sent;
            end
            r = $urandom_range(0, 9);
            send_message(len, r < 7 ? FILL_RANDOM : t_fill'(r - 6));
            sent += len;
        end
        set_idling(1'b1);
    endtask

    always @(posedge i_clk) begin : rx_side
        int unsigned gap;
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack     <= rx_hold_req;
            rx_stall_left   <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left   <= rx_stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_idle_en) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            gap = pick_gap();
            rx_stall_left   <= gap;
            i_m_axis_tready <= (gap == 0);
        end
    end

    always @(posedge i_clk) begin : check_digest
        s256_pkg::t_chain want;
        s256_pkg::t_chain got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (digest_q.size() == 0) begin
                $error("digest transfer with no message pending: %h", got);
                err_count++;
            end else begin
                want = digest_q.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got[i] !== want[i]) begin
                        $error("digest_word_%0d: expected %08h, actual %08h", i, want[i], got[i]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_hash();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_short_messages();
        test_padding_boundaries();
        test_output_backpressure();
        test_random_messages();
        i_s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
